// ----- rtl/core/buvs_pkg.sv -----
// Shared types and constants of the battery undervoltage supervisor.
// Used by the channel interfaces, the core and its checker; no dependencies.
package buvs_pkg;

  localparam int unsigned SamplesPerPoll = 10;
  localparam int unsigned SampleW        = 12;
  localparam int unsigned SumW           = 18;
  localparam int unsigned IndexW         = 6;
  localparam int unsigned MvW            = 14;
  localparam int unsigned PollW          = 8;
  localparam int unsigned CoolW          = 16;
  localparam int unsigned GainW          = 20;
  localparam int unsigned BatW           = 16;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 20;

  // Shared multiplier: operand and product widths
  localparam int unsigned MulW  = 26;
  localparam int unsigned ProdW = 2 * MulW;

  // Division by the poll length: floor(x * Recip10 / 2^Shift10), exact for x < 2^18
  localparam logic [MulW-1:0] Recip10   = MulW'(209716);
  localparam int unsigned     Shift10   = 21;
  // Converter full scale
  localparam logic [MulW-1:0] AdcFullMv = MulW'(4400);
  // Division by 4095: floor(x * Recip4095 / 2^Shift4095), exact for x < 2^25
  localparam logic [MulW-1:0] Recip4095 = MulW'(33562627);
  localparam int unsigned     Shift4095 = 37;
  localparam int unsigned     AvgW      = 12;
  localparam int unsigned     AdcMvW    = 13;
  localparam int unsigned     ScaledW   = 25;
  localparam int unsigned     GainShift = 16;

  localparam logic [MvW:0]    HystMv    = (MvW+1)'(500);

  localparam logic [MvW-1:0]   UvMvRst      = MvW'(3300);
  localparam logic [PollW-1:0] UvPollsRst   = PollW'(3);
  localparam logic [MvW-1:0]   RecMvRst     = MvW'(3600);
  localparam logic [PollW-1:0] RecPollsRst  = PollW'(3);
  localparam logic [CoolW-1:0] CoolPollsRst = CoolW'(100);
  localparam logic [GainW-1:0] GainRst      = GainW'(131072);

  typedef enum logic [CfgIdxW-1:0] {
    REG_UV_MV      = 3'd0,
    REG_UV_POLLS   = 3'd1,
    REG_REC_MV     = 3'd2,
    REG_REC_POLLS  = 3'd3,
    REG_COOL_POLLS = 3'd4,
    REG_DIV_GAIN   = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_MV,
    ST_DIV,
    ST_GAIN,
    ST_DECIDE
  } seq_state_e;

endpackage

// ----- rtl/core/buvs_if.sv -----
// Valid/ready channel interfaces of the supervisor: samples, results, config.
// Depends on buvs_pkg for field widths.
interface buvs_sample_if;
  import buvs_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface buvs_result_if;
  import buvs_pkg::*;
  logic            valid;
  logic            ready;
  logic [BatW-1:0] battery_mv;
  logic            is_low;
  logic            protected_res;
  logic            undervolt_event;
  logic            recovery_event;
  logic            cooling_down;
  modport source (output valid, output battery_mv, output is_low, output protected_res,
                  output undervolt_event, output recovery_event, output cooling_down,
                  input ready);
  modport sink   (input valid, input battery_mv, input is_low, input protected_res,
                  input undervolt_event, input recovery_event, input cooling_down,
                  output ready);
endinterface

interface buvs_cfg_if;
  import buvs_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/battery_undervoltage_supervisor_core.sv -----
// Battery undervoltage supervisor: poll averaging, scaling to battery mV and
// lockout with hysteresis. Depends on buvs_pkg and the interfaces in buvs_if.sv.
//
// Usage:
//   in_i  carries one raw 12-bit converter sample per transfer. Every tenth
//         sample closes a poll and produces one transfer on res_o; other
//         samples produce nothing.
//   res_o carries battery millivolts (saturated) and the protection flags.
//   cfg_i writes the threshold, count, cooldown and gain registers; it is
//         always ready and is meant to be written while the block is idle.
// Sequencing:
//   A sample that does not close a poll is only accumulated. A closing
//   sample is followed by four passes through the single 26x26 multiplier
//   (divide by ten, times 4400, divide by 4095, times gain) and then the
//   protection update, which loads the result register. in_i is not ready
//   during those passes or the update, so no sample of the next poll is
//   taken until the result is loaded.
// Reset clears the counts, the partial sum and protection, and loads the
// register defaults. A result waiting on a stalled receiver stays in the
// output register; samples keep flowing until the next poll closes, which
// then waits before its protection update until the result is taken.
module battery_undervoltage_supervisor_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  buvs_sample_if.sink           in_i,
  buvs_result_if.source         res_o,
  buvs_cfg_if.sink              cfg_i
);
  import buvs_pkg::*;

  // Configuration registers
  logic [MvW-1:0]   uv_mv_q;
  logic [PollW-1:0] uv_polls_q;
  logic [MvW-1:0]   rec_mv_q;
  logic [PollW-1:0] rec_polls_q;
  logic [CoolW-1:0] cool_polls_q;
  logic [GainW-1:0] gain_q;

  // Sequencer and poll state
  seq_state_e        state_q, state_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [IndexW-1:0] idx_q, idx_d;
  logic [PollW-1:0]  low_q, low_d;
  logic [PollW-1:0]  rec_q, rec_d;
  logic              prot_q, prot_d;
  logic [CoolW-1:0]  cool_q, cool_d;

  // Shared multiplier
  logic [MulW-1:0]  mul_a, mul_b;
  logic [ProdW-1:0] prod_q;
  logic             mul_en;

  // Result register
  logic            out_valid_q, out_valid_d;
  logic [BatW-1:0] bat_q;
  logic            is_low_q, prot_res_q, uv_ev_q, rc_ev_q, cool_flag_q;
  logic            load_out;

  // Decision datapath
  logic [BatW-1:0]  bat;
  logic [PollW-1:0] low_inc, rec_inc;
  logic             uv_ev, rc_ev, cool_flag, is_low;
  logic [IndexW-1:0] idx_inc;
  logic             in_fire;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uv_mv_q      <= UvMvRst;
      uv_polls_q   <= UvPollsRst;
      rec_mv_q     <= RecMvRst;
      rec_polls_q  <= RecPollsRst;
      cool_polls_q <= CoolPollsRst;
      gain_q       <= GainRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_UV_MV:      uv_mv_q      <= cfg_i.data[MvW-1:0];
        REG_UV_POLLS:   uv_polls_q   <= cfg_i.data[PollW-1:0];
        REG_REC_MV:     rec_mv_q     <= cfg_i.data[MvW-1:0];
        REG_REC_POLLS:  rec_polls_q  <= cfg_i.data[PollW-1:0];
        REG_COOL_POLLS: cool_polls_q <= cfg_i.data[CoolW-1:0];
        REG_DIV_GAIN:   gain_q       <= cfg_i.data[GainW-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the scaled product at 16 bits
  assign bat = (prod_q[ProdW-1:GainShift+BatW] != '0) ? {BatW{1'b1}}
                                                      : prod_q[GainShift +: BatW];
  assign low_inc = (low_q == {PollW{1'b1}}) ? low_q : low_q + PollW'(1);
  assign rec_inc = (rec_q == {PollW{1'b1}}) ? rec_q : rec_q + PollW'(1);
  assign idx_inc = idx_q + IndexW'(1);
  assign in_fire = in_i.valid && in_i.ready;

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    idx_d       = idx_q;
    low_d       = low_q;
    rec_d       = rec_q;
    prot_d      = prot_q;
    cool_d      = cool_q;
    uv_ev       = 1'b0;
    rc_ev       = 1'b0;
    cool_flag   = 1'b0;
    load_out    = 1'b0;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    in_i.ready  = (state_q == ST_IDLE);
    out_valid_d = out_valid_q && !res_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          sum_d = sum_q + SumW'(in_i.raw_sample);
          idx_d = idx_inc;
          if (idx_inc == IndexW'(SamplesPerPoll)) begin
            state_d = ST_AVG;
          end
        end
      end
      ST_AVG: begin
        // average = sum / 10; release the accumulator
        mul_en  = 1'b1;
        mul_a   = MulW'(sum_q);
        mul_b   = Recip10;
        sum_d   = '0;
        idx_d   = '0;
        state_d = ST_MV;
      end
      ST_MV: begin
        mul_en  = 1'b1;
        mul_a   = MulW'(prod_q[Shift10 +: AvgW]);
        mul_b   = AdcFullMv;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        mul_en  = 1'b1;
        mul_a   = MulW'(prod_q[ScaledW-1:0]);
        mul_b   = Recip4095;
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        mul_en  = 1'b1;
        mul_a   = MulW'(prod_q[Shift4095 +: AdcMvW]);
        mul_b   = MulW'(gain_q);
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        // hold until the result register is free
        if (!out_valid_q || res_o.ready) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (!prot_q) begin
            if (cool_q != '0) begin
              cool_d    = cool_q - CoolW'(1);
              cool_flag = 1'b1;
            end else if ({1'b0, bat} < (BatW+1)'(uv_mv_q)) begin
              low_d = low_inc;
              if (low_inc >= uv_polls_q) begin
                prot_d = 1'b1;
                uv_ev  = 1'b1;
              end
            end else if ({1'b0, bat} > (BatW+1)'({1'b0, uv_mv_q} + HystMv)) begin
              low_d = '0;
            end
          end else begin
            if ({1'b0, bat} >= (BatW+1)'(rec_mv_q)) begin
              rec_d = rec_inc;
              if (rec_inc >= rec_polls_q) begin
                prot_d = 1'b0;
                low_d  = '0;
                rec_d  = '0;
                cool_d = cool_polls_q;
                rc_ev  = 1'b1;
              end
            end else if (({1'b0, bat} + (BatW+1)'(HystMv)) < (BatW+1)'(rec_mv_q)) begin
              rec_d = '0;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign is_low = (low_d >= uv_polls_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      idx_q       <= '0;
      low_q       <= '0;
      rec_q       <= '0;
      prot_q      <= 1'b0;
      cool_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      idx_q       <= idx_d;
      low_q       <= low_d;
      rec_q       <= rec_d;
      prot_q      <= prot_d;
      cool_q      <= cool_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (load_out) begin
      bat_q       <= bat;
      is_low_q    <= is_low;
      prot_res_q  <= prot_d;
      uv_ev_q     <= uv_ev;
      rc_ev_q     <= rc_ev;
      cool_flag_q <= cool_flag;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.battery_mv      = bat_q;
  assign res_o.is_low          = is_low_q;
  assign res_o.protected_res   = prot_res_q;
  assign res_o.undervolt_event = uv_ev_q;
  assign res_o.recovery_event  = rc_ev_q;
  assign res_o.cooling_down    = cool_flag_q;

endmodule

// ----- rtl/core/buvs_checker.sv -----
// Port-level checks on the supervisor's result channel, bound to the core.
// Depends on buvs_pkg and battery_undervoltage_supervisor_core.
module buvs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          res_valid_i,
  input logic                          res_ready_i,
  input logic [buvs_pkg::BatW-1:0]     res_battery_mv_i,
  input logic                          protected_res_i,
  input logic                          undervolt_event_i,
  input logic                          recovery_event_i,
  input logic                          cooling_down_i
);
  import buvs_pkg::*;

  // A stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  a_uv_protects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && undervolt_event_i |-> protected_res_i && !recovery_event_i)
    else $error("undervoltage event without protection");

  a_rc_releases: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && recovery_event_i |-> !protected_res_i && !cooling_down_i)
    else $error("recovery event while still protected or cooling");

  a_cool_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && cooling_down_i |-> !protected_res_i && !undervolt_event_i)
    else $error("cooldown poll changed protection");

  // A stalled result keeps its value
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_battery_mv_i))
    else $error("result value moved while stalled");

endmodule

bind battery_undervoltage_supervisor_core buvs_checker u_buvs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .res_valid_i       (res_o.valid),
  .res_ready_i       (res_o.ready),
  .res_battery_mv_i  (res_o.battery_mv),
  .protected_res_i   (res_o.protected_res),
  .undervolt_event_i (res_o.undervolt_event),
  .recovery_event_i  (res_o.recovery_event),
  .cooling_down_i    (res_o.cooling_down)
);

// ----- sim/battery_undervoltage_supervisor_core_tb.sv -----
// Self-checking bench for battery_undervoltage_supervisor_core: directed polls, then
// phases of random polls under several register settings and handshake patterns.
// Depends on buvs_pkg and the channel interfaces in buvs_if.sv.
module battery_undervoltage_supervisor_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import buvs_pkg::*;

  localparam int unsigned ClkPeriod    = 12;
  localparam int unsigned ResetCycles  = 12;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned LongHold     = 200;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned PollsPerPhase = 7;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned AdcFullCode  = 4095;
  localparam int unsigned MaxReported  = 10;
  // indexes past the register list; writes there must be dropped
  localparam logic [CfgIdxW-1:0] RegBeyondLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegBeyondHi = 3'd7;

  typedef struct packed {
    logic [BatW-1:0] battery_mv;
    logic            is_low;
    logic            protected_res;
    logic            undervolt_event;
    logic            recovery_event;
    logic            cooling_down;
  } poll_result_t;

  typedef struct packed {
    logic [SampleW-1:0] raw;
    logic [3:0]         reps;
    logic               typed;
    poll_result_t       typed_res;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  buvs_sample_if smp_if ();
  buvs_result_if res_if ();
  buvs_cfg_if    cfg_if ();

  battery_undervoltage_supervisor_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // supervisor shadow: registers and protection state
  int unsigned uv_mv_q      = UvMvRst;
  int unsigned uv_polls_q   = UvPollsRst;
  int unsigned rec_mv_q     = RecMvRst;
  int unsigned rec_polls_q  = RecPollsRst;
  int unsigned cool_polls_q = CoolPollsRst;
  int unsigned gain_q       = GainRst;
  logic [SumW-1:0]   acc_sum = '0;
  logic [IndexW-1:0] acc_cnt = '0;
  int unsigned low_run   = 0;
  int unsigned good_run  = 0;
  bit          in_lockout = 1'b0;
  int unsigned cool_left = 0;

  poll_result_t pending_polls [$];
  int unsigned  fail_cnt = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  bit           hold_req = 1'b0;
  int unsigned  cycle_cnt = 0;
  stim_row_t    dir_rows [0:4];

  function automatic void apply_cfg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      REG_UV_MV:      uv_mv_q      = data[MvW-1:0];
      REG_UV_POLLS:   uv_polls_q   = data[PollW-1:0];
      REG_REC_MV:     rec_mv_q     = data[MvW-1:0];
      REG_REC_POLLS:  rec_polls_q  = data[PollW-1:0];
      REG_COOL_POLLS: cool_polls_q = data[CoolW-1:0];
      REG_DIV_GAIN:   gain_q       = data[GainW-1:0];
      default: ;
    endcase
  endfunction

  // Accumulate one sample; on the tenth, scale the poll and run the lockout machine.
  function automatic bit predict_poll(input logic [SampleW-1:0] raw, output poll_result_t r);
    longint unsigned avg, adc_mv, scaled;
    int unsigned bat;
    r = '0;
    acc_sum = acc_sum + SumW'(raw);
    acc_cnt = acc_cnt + 1'b1;
    if (acc_cnt < SamplesPerPoll) return 1'b0;
    avg    = acc_sum / SamplesPerPoll;
    adc_mv = avg * AdcFullMv / AdcFullCode;
    scaled = (adc_mv * gain_q) >> GainShift;
    bat    = (scaled > 65535) ? 65535 : int'(scaled);
    acc_sum = '0;
    acc_cnt = '0;
    if (!in_lockout) begin
      if (cool_left != 0) begin
        cool_left--;
        r.cooling_down = 1'b1;
      end else if (bat < uv_mv_q) begin
        if (low_run < 255) low_run++;
        if (low_run >= uv_polls_q) begin
          in_lockout = 1'b1;
          r.undervolt_event = 1'b1;
        end
      end else if (bat > uv_mv_q + HystMv) begin
        low_run = 0;
      end
    end else begin
      if (bat >= rec_mv_q) begin
        if (good_run < 255) good_run++;
        if (good_run >= rec_polls_q) begin
          in_lockout = 1'b0;
          low_run    = 0;
          good_run   = 0;
          cool_left  = cool_polls_q;
          r.recovery_event = 1'b1;
        end
      end else if (bat + HystMv < rec_mv_q) begin
        good_run = 0;
      end
    end
    r.battery_mv    = BatW'(bat);
    r.is_low        = (low_run >= uv_polls_q);
    r.protected_res = in_lockout;
    return 1'b1;
  endfunction

  task automatic note_failure(input string what);
    fail_cnt++;
    if (fail_cnt <= MaxReported) $display("%0t ns: %s", $time, what);
  endtask

  // Offer one sample at the falling edge, hold until the transfer, then predict.
  task automatic send_sample(input logic [SampleW-1:0] raw, input bit typed,
                             input poll_result_t typed_res);
    poll_result_t r;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      smp_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    smp_if.valid      <= 1'b1;
    smp_if.raw_sample <= raw;
    @(posedge clk_i);
    while (!smp_if.ready) @(posedge clk_i);
    if (predict_poll(raw, r)) pending_polls.push_back(typed ? typed_res : r);
  endtask

  // Pick a target level from the current state so trips and recoveries get exercised; one poll in ten is fully random.
  task automatic send_poll();
    int unsigned pick, target, code;
    longint unsigned num;
    int s;
    pick = $urandom_range(99);
    if (pick < 10) begin
      for (int k = 0; k < SamplesPerPoll; k++) begin
        send_sample(SampleW'($urandom_range(4095)), 1'b0, '0);
      end
      return;
    end
    if (in_lockout) begin
      if (pick < 55)
        target = (rec_mv_q > 600 ? rec_mv_q - 600 : 0) + $urandom_range(800);
      else if (pick < 80)
        target = uv_mv_q + 500 + $urandom_range(1500);
      else
        target = (uv_mv_q > 0) ? $urandom_range(uv_mv_q - 1) : 0;
    end else begin
      if (pick < 60)
        target = (uv_mv_q > 0) ?
                 $urandom_range(uv_mv_q - 1, (uv_mv_q > 400) ? uv_mv_q - 400 : 0) : 0;
      else if (pick < 75)
        target = uv_mv_q + $urandom_range(500);
      else
        target = uv_mv_q + 501 + $urandom_range(2000);
    end
    if (gain_q == 0) begin
      code = $urandom_range(4095);
    end else begin
      num  = (64'(target) << GainShift) * AdcFullCode / (64'(gain_q) * AdcFullMv);
      code = (num > AdcFullCode) ? AdcFullCode : int'(num);
    end
    for (int k = 0; k < SamplesPerPoll; k++) begin
      s = int'(code) + int'($urandom_range(4)) - 2;
      if (s < 0) s = 0;
      if (s > int'(AdcFullCode)) s = AdcFullCode;
      send_sample(SampleW'(s), 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    apply_cfg(idx, data);
  endtask

  task automatic set_regs(input logic [CfgDataW-1:0] uv, input logic [CfgDataW-1:0] uvp,
                          input logic [CfgDataW-1:0] rec, input logic [CfgDataW-1:0] recp,
                          input logic [CfgDataW-1:0] cool, input logic [CfgDataW-1:0] gain);
    write_reg(REG_UV_MV, uv);
    write_reg(REG_UV_POLLS, uvp);
    write_reg(REG_REC_MV, rec);
    write_reg(REG_REC_POLLS, recp);
    write_reg(REG_COOL_POLLS, cool);
    write_reg(REG_DIV_GAIN, gain);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Drop valid, wait for every pending poll, then let trailing samples settle.
  task automatic drain();
    @(negedge clk_i);
    smp_if.valid <= 1'b0;
    while (pending_polls.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    smp_if.valid      = 1'b0;
    smp_if.raw_sample = '0;
    res_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    poll_result_t got, want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = {res_if.battery_mv, res_if.is_low, res_if.protected_res,
             res_if.undervolt_event, res_if.recovery_event, res_if.cooling_down};
      if (pending_polls.size() == 0) begin
        note_failure($sformatf("unexpected poll result %0d mV flags %b",
                               got.battery_mv, got[4:0]));
      end else begin
        want = pending_polls.pop_front();
        if (got.battery_mv !== want.battery_mv || got.is_low !== want.is_low ||
            got.protected_res !== want.protected_res ||
            got.undervolt_event !== want.undervolt_event ||
            got.recovery_event !== want.recovery_event ||
            got.cooling_down !== want.cooling_down)
          // flags in order low, prot, uv, rec, cool
          note_failure($sformatf("poll mismatch exp %0d mV flags %b, got %0d mV flags %b",
                                 want.battery_mv, want[4:0], got.battery_mv, got[4:0]));
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("battery_undervoltage_supervisor_core verification failed");
    $finish;
  end

  initial begin
    // raw, reps, typed, battery_mv, is_low/protected/undervolt/recovery/cooling
    dir_rows[0] = {12'hFFF, 4'd10, 1'b1, 16'd8800, 5'b00000};
    dir_rows[1] = {12'h000, 4'd10, 1'b1, 16'd0,    5'b00000};
    dir_rows[2] = {12'hAAA, 4'd2,  1'b0, 16'd0,    5'b00000};
    dir_rows[3] = {12'h555, 4'd2,  1'b0, 16'd0,    5'b00000};
    dir_rows[4] = {12'h800, 4'd1,  1'b0, 16'd0,    5'b00000};

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < 5; i++)
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_sample(dir_rows[i].raw, dir_rows[i].typed, dir_rows[i].typed_res);
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_regs(3300, 1, 3600, 1, 2, 131072);
        end
        1: begin
          send_idle_pct = 79; recv_stall_pct = 0;
          set_regs(CfgDataW'($urandom_range(4500, 2500)), 2, 0, 2,
                   CfgDataW'($urandom_range(1)), 0);
          // keep recovery above the trip level
          write_reg(REG_REC_MV, CfgDataW'(uv_mv_q + $urandom_range(800, 200)));
          write_reg(REG_DIV_GAIN, CfgDataW'($urandom_range(140000, 120000)));
          @(negedge clk_i);
          cfg_if.valid <= 1'b0;
        end
        2: begin
          // zero poll counts, recovery level under the hysteresis band
          send_idle_pct = 0;  recv_stall_pct = 79;
          set_regs(3300, 0, 300, 0, 1, 131072);
        end
        3: begin
          // all ones: top of every register, saturating gain
          send_idle_pct = 9;  recv_stall_pct = 9;
          set_regs('1, '1, '1, '1, '1, '1);
        end
        4: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          write_reg(RegBeyondLo, '1);
          write_reg(RegBeyondHi, '1);
          set_regs('0, '0, '0, '0, '0, '0);
        end
        default: begin
          send_idle_pct = 0;  recv_stall_pct = 0;
          set_regs(3300, 3, 3600, 3, 3, 131072);
          hold_req = 1'b1;
        end
      endcase
      for (int p = 0; p < PollsPerPhase; p++) begin
        send_poll();
        if (ph == 1 && p == 3) drain();
      end
      drain();
    end

    if (fail_cnt == 0 && pending_polls.size() == 0)
      $display("battery_undervoltage_supervisor_core verification clean");
    else
      $display("battery_undervoltage_supervisor_core verification failed");
    $finish;
  end

endmodule
